### design/ud2e_pkg.sv
`timescale 1ns / 1ps
package ud2e_pkg;

    localparam int CENTURY_BASE = 2000;
    localparam int EPOCH_YEAR   = 1970;

    localparam int YEAR_W  = 7;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int ZONE_W  = 27;
    localparam int OUT_W   = 42;

    localparam int YEAR_COUNT = 1 << YEAR_W;
    localparam int YDAYS_W    = 18;   // days from epoch to Jan 1 of the latest year
    localparam int MDAYS_W    = 9;    // days from Jan 1 to the first of a month
    localparam int DAYS_W     = 20;   // signed day count, day zero may go below
    localparam int ACC_W      = 48;   // signed milliseconds
    localparam int MUL_A_W    = 38;   // signed seconds operand
    localparam int MUL_B_W    = 17;   // unsigned constant operand
    localparam int PROD_W     = MUL_A_W + MUL_B_W + 1;

    localparam logic [ZONE_W-1:0]  ZONE_RESET = ZONE_W'(28800000);
    localparam logic [MUL_B_W-1:0] K_DAY  = MUL_B_W'(86400);
    localparam logic [MUL_B_W-1:0] K_HOUR = MUL_B_W'(3600);
    localparam logic [MUL_B_W-1:0] K_MIN  = MUL_B_W'(60);
    localparam logic [MUL_B_W-1:0] K_ONE  = MUL_B_W'(1);
    localparam logic [MUL_B_W-1:0] K_MS   = MUL_B_W'(1000);
    localparam logic [OUT_W-1:0]   OUT_MAX = '1;

    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_DAY   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_HOUR  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_MIN   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_SEC   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_SCALE = 3'd4;

    typedef logic [YDAYS_W-1:0] year_days_t [YEAR_COUNT];
    typedef logic [YEAR_COUNT-1:0] leap_flags_t;

    typedef struct packed {
        logic              load;
        logic              step_en;
        logic [STEP_W-1:0] step;
        logic              out_load;
    } ud2e_cmd_t;

    function automatic bit is_leap(int y);
        if (y % 4 != 0) return 1'b0;
        if (y % 100 != 0) return 1'b1;
        return (y % 400) == 0;
    endfunction

    // Days from the epoch to Jan 1 of each year of the century
    function automatic year_days_t build_year_days();
        year_days_t t;
        int d;
        int y;
        d = 0;
        for (y = EPOCH_YEAR; y < CENTURY_BASE; y++)
            d += is_leap(y) ? 366 : 365;
        for (int i = 0; i < YEAR_COUNT; i++)
        begin
            t[i] = YDAYS_W'(d);
            d += is_leap(CENTURY_BASE + i) ? 366 : 365;
        end
        return t;
    endfunction

    function automatic leap_flags_t build_leap_flags();
        leap_flags_t f;
        for (int i = 0; i < YEAR_COUNT; i++)
            f[i] = is_leap(CENTURY_BASE + i);
        return f;
    endfunction

    localparam year_days_t  YEAR_DAYS  = build_year_days();
    localparam leap_flags_t LEAP_FLAGS = build_leap_flags();

    // Days before the first of the month; out-of-range months clamp to Jan / Dec
    function automatic logic [MDAYS_W-1:0] month_start(logic [MONTH_W-1:0] m, logic leap);
        logic [MDAYS_W-1:0] d;
        case (m) inside
            4'd0, 4'd1:      d = MDAYS_W'(0);
            4'd2:            d = MDAYS_W'(31);
            4'd3:            d = MDAYS_W'(59);
            4'd4:            d = MDAYS_W'(90);
            4'd5:            d = MDAYS_W'(120);
            4'd6:            d = MDAYS_W'(151);
            4'd7:            d = MDAYS_W'(181);
            4'd8:            d = MDAYS_W'(212);
            4'd9:            d = MDAYS_W'(243);
            4'd10:           d = MDAYS_W'(273);
            4'd11:           d = MDAYS_W'(304);
            [4'd12:4'd15]:   d = MDAYS_W'(334);
            default:         d = MDAYS_W'(0);
        endcase
        if (leap && m > 4'd2)
            d = d + MDAYS_W'(1);
        return d;
    endfunction

endpackage

### design/utc_date_to_epoch_ms_unit.sv
`timescale 1ns / 1ps
// Converts a UTC date and time (year 0..127 past 2000, month, day, hour,
// minute, whole seconds) into milliseconds since 1970-01-01, less the zone
// offset held in a 27-bit signed register, clamped to 0 .. 2^42-1.
// Input channel: in_valid / in_stall with the six date fields; a transfer
// happens on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with epoch_ms, same rule.
// Configuration: cfg_we with cfg_wdata writes the zone offset (8 hours
// after reset); write it only while no conversion is in flight.
// Sequence: a day-count lookup is followed by five passes through one
// shared multiplier (days, hours, minutes, seconds, scale to milliseconds)
// and the offset step, whose result is loaded into the output register.
// A new date is taken only once the previous result is loaded; in_stall
// stays high from the input transfer until the result is loaded.
// Stalled receiver: the result waits in the output register; the next item
// may be taken and worked on, and holds before its final step until the
// register frees up.
// Reset: both channels go idle and the zone offset returns to eight hours.
module utc_date_to_epoch_ms_unit
    import ud2e_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [ZONE_W-1:0]  cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [YEAR_W-1:0]  year_of_century,
    input  logic [MONTH_W-1:0] month_number,
    input  logic [DAY_W-1:0]   day_of_month,
    input  logic [HOUR_W-1:0]  hour_of_day,
    input  logic [MIN_W-1:0]   minute_of_hour,
    input  logic [SEC_W-1:0]   whole_seconds,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [OUT_W-1:0]   epoch_ms
);

    ud2e_cmd_t cmd;

    ud2e_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    ud2e_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .year_of_century (year_of_century),
        .month_number    (month_number),
        .day_of_month    (day_of_month),
        .hour_of_day     (hour_of_day),
        .minute_of_hour  (minute_of_hour),
        .whole_seconds   (whole_seconds),
        .epoch_ms        (epoch_ms)
    );

endmodule

### design/ud2e_ctrl.sv
`timescale 1ns / 1ps
module ud2e_ctrl
    import ud2e_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output ud2e_cmd_t cmd
);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] S_IDLE  = 3'd0;
    localparam logic [ST_W-1:0] S_DAY   = 3'd1;
    localparam logic [ST_W-1:0] S_HOUR  = 3'd2;
    localparam logic [ST_W-1:0] S_MIN   = 3'd3;
    localparam logic [ST_W-1:0] S_SEC   = 3'd4;
    localparam logic [ST_W-1:0] S_SCALE = 3'd5;
    localparam logic [ST_W-1:0] S_OUT   = 3'd6;

    logic [ST_W-1:0] state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.step     = STEP_DAY;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DAY;
                end
            end
            S_DAY:
            begin
                cmd.step_en = 1'b1;
                cmd.step    = STEP_DAY;
                state_next  = S_HOUR;
            end
            S_HOUR:
            begin
                cmd.step_en = 1'b1;
                cmd.step    = STEP_HOUR;
                state_next  = S_MIN;
            end
            S_MIN:
            begin
                cmd.step_en = 1'b1;
                cmd.step    = STEP_MIN;
                state_next  = S_SEC;
            end
            S_SEC:
            begin
                cmd.step_en = 1'b1;
                cmd.step    = STEP_SEC;
                state_next  = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.step_en = 1'b1;
                cmd.step    = STEP_SCALE;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                // wait here until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_DAY)
        else $error("accepted transfer did not start the sequence");

    a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_OUT)
        else $error("result shown without finishing the sequence");

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && out_valid && out_stall |=> state_reg == S_OUT)
        else $error("result overwrote a pending transfer");

endmodule

### design/ud2e_dpath.sv
`timescale 1ns / 1ps
module ud2e_dpath
    import ud2e_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ud2e_cmd_t          cmd,
    input  logic               cfg_we,
    input  logic [ZONE_W-1:0]  cfg_wdata,
    input  logic [YEAR_W-1:0]  year_of_century,
    input  logic [MONTH_W-1:0] month_number,
    input  logic [DAY_W-1:0]   day_of_month,
    input  logic [HOUR_W-1:0]  hour_of_day,
    input  logic [MIN_W-1:0]   minute_of_hour,
    input  logic [SEC_W-1:0]   whole_seconds,
    output logic [OUT_W-1:0]   epoch_ms
);

    logic [ZONE_W-1:0]        zone_reg;
    logic signed [DAYS_W-1:0] days_reg, days_next;
    logic [HOUR_W-1:0]        hour_reg;
    logic [MIN_W-1:0]         minute_reg;
    logic [SEC_W-1:0]         second_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [OUT_W-1:0]         epoch_reg, epoch_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic signed [ACC_W-1:0]   add_base;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W:0]     diff;

    // day count of the date from year table, month table and day
    always_comb
    begin
        days_next = signed'(DAYS_W'(YEAR_DAYS[year_of_century]))
                  + signed'(DAYS_W'(month_start(month_number, LEAP_FLAGS[year_of_century])))
                  + signed'(DAYS_W'(day_of_month))
                  - signed'(DAYS_W'(1));
    end

    // one shared multiplier, one step per cycle
    always_comb
    begin
        mul_a    = '0;
        mul_b    = K_ONE;
        add_base = acc_reg;
        case (cmd.step)
            STEP_DAY:
            begin
                mul_a    = {{(MUL_A_W-DAYS_W){days_reg[DAYS_W-1]}}, days_reg};
                mul_b    = K_DAY;
                add_base = '0;
            end
            STEP_HOUR:
            begin
                mul_a = {{(MUL_A_W-HOUR_W){1'b0}}, hour_reg};
                mul_b = K_HOUR;
            end
            STEP_MIN:
            begin
                mul_a = {{(MUL_A_W-MIN_W){1'b0}}, minute_reg};
                mul_b = K_MIN;
            end
            STEP_SEC:
            begin
                mul_a = {{(MUL_A_W-SEC_W){1'b0}}, second_reg};
                mul_b = K_ONE;
            end
            STEP_SCALE:
            begin
                mul_a    = acc_reg[MUL_A_W-1:0];
                mul_b    = K_MS;
                add_base = '0;
            end
            default:
            begin
                mul_a    = '0;
                mul_b    = K_ONE;
                add_base = acc_reg;
            end
        endcase
        prod     = mul_a * signed'({1'b0, mul_b});
        acc_next = add_base + prod[ACC_W-1:0];
    end

    // subtract the zone offset, then clamp to the output range
    always_comb
    begin
        diff = {acc_reg[ACC_W-1], acc_reg}
             - {{(ACC_W+1-ZONE_W){zone_reg[ZONE_W-1]}}, zone_reg};
        if (diff[ACC_W])
            epoch_next = '0;
        else if (|diff[ACC_W-1:OUT_W])
            epoch_next = OUT_MAX;
        else
            epoch_next = diff[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            zone_reg <= ZONE_RESET;
        else if (cfg_we)
            zone_reg <= cfg_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            days_reg   <= days_next;
            hour_reg   <= hour_of_day;
            minute_reg <= minute_of_hour;
            second_reg <= whole_seconds;
        end
        if (cmd.step_en)
            acc_reg <= acc_next;
        if (cmd.out_load)
            epoch_reg <= epoch_next;
    end

    assign epoch_ms = epoch_reg;

endmodule

### tb/utc_date_to_epoch_ms_unit_tb.sv
`timescale 1ns / 1ps
module utc_date_to_epoch_ms_unit_tb;
    import ud2e_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 12;
    localparam int MAX_SHOWN   = 10;

    localparam longint MS_CEILING = (longint'(1) << OUT_W) - 1;
    localparam int DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam logic signed [ZONE_W-1:0] ZONE_MOST  = {1'b0, {(ZONE_W-1){1'b1}}};
    localparam logic signed [ZONE_W-1:0] ZONE_LEAST = {1'b1, {(ZONE_W-1){1'b0}}};

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } utc_date_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [ZONE_W-1:0]  cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic [YEAR_W-1:0]  year_of_century;
    logic [MONTH_W-1:0] month_number;
    logic [DAY_W-1:0]   day_of_month;
    logic [HOUR_W-1:0]  hour_of_day;
    logic [MIN_W-1:0]   minute_of_hour;
    logic [SEC_W-1:0]   whole_seconds;
    logic               out_valid;
    logic               out_stall;
    logic [OUT_W-1:0]   epoch_ms;

    logic signed [ZONE_W-1:0] zone_ms;
    logic [OUT_W-1:0]         expected_ms_q [$];
    bit                       idling_on;
    int                       hold_request;
    int                       dates_sent;
    int                       results_checked;
    int                       mismatches;
    int                       saturated_high;
    int                       zone_writes;
    int                       cycle_count;

    utc_date_to_epoch_ms_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .year_of_century (year_of_century),
        .month_number    (month_number),
        .day_of_month    (day_of_month),
        .hour_of_day     (hour_of_day),
        .minute_of_hour  (minute_of_hour),
        .whole_seconds   (whole_seconds),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .epoch_ms        (epoch_ms)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #CLK_HALF clk = ~clk;
    end

    function automatic bit gregorian_leap(longint yr);
        if (yr % 400 == 0)
            return 1'b1;
        if (yr % 100 == 0)
            return 1'b0;
        return (yr % 4) == 0;
    endfunction

    // Milliseconds since 1970 for one date, less the zone, clamped to the output range
    function automatic logic [OUT_W-1:0] epoch_ms_of(utc_date_t d,
                                                      logic signed [ZONE_W-1:0] zone);
        longint full_year;
        longint day_count;
        longint ms;
        int     last_month;
        full_year = longint'(CENTURY_BASE) + longint'(d.year);
        day_count = 0;
        for (longint y = EPOCH_YEAR; y < full_year; y++)
            day_count += gregorian_leap(y) ? 366 : 365;
        // month zero counts as January, anything past twelve as December
        last_month = (d.month == 0) ? 1 : (d.month > 12) ? 12 : int'(d.month);
        for (int m = 0; m < last_month - 1; m++)
            day_count += DAYS_IN_MONTH[m] + ((m == 1 && gregorian_leap(full_year)) ? 1 : 0);
        day_count += longint'(d.day) - 1;
        ms = (day_count * 86400 + longint'(d.hour) * 3600 + longint'(d.minute) * 60
              + longint'(d.second)) * 1000 - longint'(zone);
        if (ms < 0)
            ms = 0;
        if (ms > MS_CEILING)
            ms = MS_CEILING;
        return OUT_W'(ms);
    endfunction

    function automatic utc_date_t make_date(int yr, int mo, int dy, int hr, int mi, int se);
        utc_date_t d;
        d.year   = YEAR_W'(yr);
        d.month  = MONTH_W'(mo);
        d.day    = DAY_W'(dy);
        d.hour   = HOUR_W'(hr);
        d.minute = MIN_W'(mi);
        d.second = SEC_W'(se);
        return d;
    endfunction

    // Well-formed dates stay inside the calendar; the rest use every bit of every field
    function automatic utc_date_t random_date(bit well_formed);
        utc_date_t d;
        int        month_len;
        d = utc_date_t'({$urandom, $urandom});
        if (well_formed)
        begin
            d.month = MONTH_W'($urandom_range(12, 1));
            month_len = DAYS_IN_MONTH[d.month - 1];
            if (d.month == 2 && gregorian_leap(longint'(CENTURY_BASE) + longint'(d.year)))
                month_len = 29;
            d.day    = DAY_W'($urandom_range(month_len, 1));
            d.hour   = HOUR_W'($urandom_range(23, 0));
            d.minute = MIN_W'($urandom_range(59, 0));
            d.second = SEC_W'($urandom_range(60, 0));
        end
        return d;
    endfunction

    // Offer one date and hold it until the block takes it; returns at a falling edge
    task automatic send_date(utc_date_t d);
        logic [OUT_W-1:0] predicted;
        if (idling_on && $urandom_range(99) < 30)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        in_valid        = 1'b1;
        year_of_century = d.year;
        month_number    = d.month;
        day_of_month    = d.day;
        hour_of_day     = d.hour;
        minute_of_hour  = d.minute;
        whole_seconds   = d.second;
        do
            @(posedge clk);
        while (in_stall);
        predicted = epoch_ms_of(d, zone_ms);
        if (predicted == OUT_MAX)
            saturated_high++;
        expected_ms_q.push_back(predicted);
        dates_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (expected_ms_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_zone(logic signed [ZONE_W-1:0] zone);
        drain_results();
        cfg_we    = 1'b1;
        cfg_wdata = zone;
        @(negedge clk);
        cfg_we  = 1'b0;
        zone_ms = zone;
        zone_writes++;
    endtask

    // Receiver: random stall while idling_on is set, else none, or a long hold-off when one is requested
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else if (idling_on)
                out_stall = ($urandom_range(99) < 30);
            else
                out_stall = 1'b0;
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        logic [OUT_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_ms_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("[%0t] unexpected result epoch_ms=%0d", $realtime, epoch_ms);
            end
            else
            begin
                want = expected_ms_q.pop_front();
                results_checked++;
                if (epoch_ms !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("[%0t] epoch_ms expected %0d got %0d",
                                 $realtime, want, epoch_ms);
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_ms_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic test_calendar_corners();
        // year 2000 is a leap century, 2100 is not
        send_date(make_date(0, 1, 1, 0, 0, 0));
        send_date(make_date(0, 2, 29, 12, 0, 0));
        send_date(make_date(0, 3, 1, 0, 0, 0));
        send_date(make_date(4, 2, 29, 23, 59, 59));
        send_date(make_date(4, 12, 31, 23, 59, 60));
        send_date(make_date(99, 12, 31, 23, 59, 60));
        send_date(make_date(100, 2, 28, 0, 0, 0));
        send_date(make_date(100, 3, 1, 0, 0, 0));
        send_date(make_date(127, 1, 1, 0, 0, 0));
        // month zero acts as January, months past twelve as December
        send_date(make_date(24, 0, 15, 6, 30, 0));
        send_date(make_date(24, 13, 15, 6, 30, 0));
        send_date(make_date(24, 15, 31, 6, 30, 0));
        // day zero steps back one day before the first
        send_date(make_date(0, 1, 0, 0, 0, 0));
        send_date(make_date(0, 0, 0, 0, 0, 0));
        send_date(make_date(25, 3, 0, 7, 59, 59));
        // time fields past their normal range add linearly
        send_date(make_date(10, 6, 31, 31, 63, 63));
        send_date(make_date(10, 6, 1, 24, 60, 61));
        // far end of the year field runs past the output range
        send_date(make_date(127, 15, 31, 31, 63, 63));
        send_date(make_date(126, 12, 31, 23, 59, 59));
        send_date(make_date(85, 7, 4, 12, 34, 56));
        drain_results();
    endtask

    task automatic test_zone_offsets();
        logic signed [ZONE_W-1:0] zones [7];
        zones = '{ZONE_W'(0), -ZONE_W'(50400000), ZONE_W'(50400000), ZONE_LEAST, ZONE_MOST,
                  ZONE_W'($urandom), ZONE_RESET};
        foreach (zones[i])
        begin
            write_zone(zones[i]);
            send_date(make_date(0, 1, 1, 0, 0, 0));
            send_date(make_date(0, 1, 0, 0, 0, 0));
            send_date(make_date(127, 15, 31, 31, 63, 63));
            send_date(make_date(106, 12, 1, 0, 0, 0));
            repeat (4) send_date(random_date($urandom_range(3) != 0));
        end
        drain_results();
    endtask

    task automatic test_output_holdoff();
        hold_request = 250;
        // keep offering while the receiver holds off, so the block backs up
        repeat (12) send_date(random_date(1'b1));
        drain_results();
    endtask

    task automatic test_random_dates(int count, bit with_idling);
        idling_on = with_idling;
        for (int i = 0; i < count; i++)
            send_date(random_date($urandom_range(99) < 80));
        drain_results();
        idling_on = 1'b1;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        in_valid        = 1'b0;
        year_of_century = '0;
        month_number    = '0;
        day_of_month    = '0;
        hour_of_day     = '0;
        minute_of_hour  = '0;
        whole_seconds   = '0;
        zone_ms         = ZONE_RESET;
        idling_on       = 1'b1;
        hold_request    = 0;
        dates_sent      = 0;
        results_checked = 0;
        mismatches      = 0;
        saturated_high  = 0;
        zone_writes     = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_calendar_corners();
        test_zone_offsets();
        test_output_holdoff();
        test_random_dates(300, 1'b1);
        test_random_dates(150, 1'b0);
        write_zone(ZONE_W'($urandom));
        test_random_dates(120, 1'b1);

        drain_results();
        $display("%0d dates converted and %0d results checked across %0d zone settings,",
                 dates_sent, results_checked, zone_writes);
        $display("%0d of them clamped at the top of the range, %0d mismatches",
                 saturated_high, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
